// ===== sv/lav_pkg.sv =====
// Shared constants, widths and rounding helper for the look-at view matrix block.
// No dependencies; used by lav_norm and look_at_view_matrix.
package lav_pkg;

    localparam int FRAC_BITS = 16;               // fractional bits of Q.F values
    localparam int VAL_W     = 32;               // width of one Q.F field
    localparam int AX_W      = FRAC_BITS + 2;    // signed unit-axis component, |x| <= 2^F
    localparam int CR_W      = FRAC_BITS + 34;   // signed cross product / axis*pos product
    localparam int NORM_LAT  = FRAC_BITS + 40;   // lav_norm input-to-output register count
    localparam int IN_W      = 9 * VAL_W;
    localparam int OUT_W     = 4 * VAL_W;
    localparam int USER_W    = 3;

    localparam logic [1:0] ROW_LAST = 2'd3;      // constant row 0,0,0,1

    // Shift right by FRAC_BITS, rounding half away from zero.
    function automatic logic signed [63:0] lav_round(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? 64'(-v) : 64'(v);
        q = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== sv/lav_norm.sv =====
// Pipelined 3-vector normalizer: range shift, sum of squares, digit-serial
// square root and restoring division, one stage per digit. Uses lav_pkg.
module lav_norm (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [lav_pkg::CR_W-1:0]  i_v    [3],
    output logic signed [lav_pkg::AX_W-1:0]  o_axis [3],
    output logic                             o_zero
);

    localparam int F     = lav_pkg::FRAC_BITS;
    localparam int MAG_W = lav_pkg::CR_W;
    localparam int SH_W  = $clog2(MAG_W);
    localparam int A_W   = 30;
    localparam int LEN_W = 31;
    localparam int SQ_N  = 32;
    localparam int Q_W   = F + 1;
    localparam int DV_W  = A_W + F + 2;
    localparam int AX_W  = lav_pkg::AX_W;

    typedef struct packed {
        logic [63:0]             n;
        logic [63:0]             root;
        logic [2:0][A_W-1:0]     a;
        logic [2:0]              neg;
    } t_sq;

    typedef struct packed {
        logic [LEN_W-1:0]        len;
        logic [2:0][DV_W-1:0]    rem;
        logic [2:0][Q_W-1:0]     q;
        logic [2:0]              neg;
    } t_dv;

    logic [2:0][MAG_W-1:0]   w_mag;
    logic [MAG_W-1:0]        w_max;
    logic [SH_W-1:0]         w_k;

    logic [2:0][MAG_W-1:0]   r_s1_a;
    logic [2:0]              r_s1_neg;
    logic [MAG_W-1:0]        r_s1_m;
    logic [2:0][MAG_W-1:0]   r_s2_a;
    logic [2:0]              r_s2_neg;
    logic [SH_W-1:0]         r_s2_k;
    logic [2:0][A_W-1:0]     r_s3_a;
    logic [2:0]              r_s3_neg;
    logic [2:0][2*A_W-1:0]   r_s4_sq;
    logic [2:0][A_W-1:0]     r_s4_a;
    logic [2:0]              r_s4_neg;
    logic [63:0]             r_s5_n;
    logic [2:0][A_W-1:0]     r_s5_a;
    logic [2:0]              r_s5_neg;

    t_sq w_sq_in [SQ_N];
    t_sq n_sq    [SQ_N];
    t_sq r_sq    [SQ_N];
    t_dv n_dv0;
    t_dv n_dv    [Q_W];
    t_dv r_dv    [Q_W+1];
    logic signed [AX_W-1:0] w_q [3];

    function automatic t_sq sq_step(input t_sq x, input int j);
        logic [63:0] b;
        t_sq y;
        b = 64'(1) << (2 * j);
        y = x;
        if (x.n >= x.root + b) begin
            y.n    = x.n - (x.root + b);
            y.root = (x.root >> 1) + b;
        end else begin
            y.root = x.root >> 1;
        end
        return y;
    endfunction

    // magnitudes and largest magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_v[i][MAG_W-1] ? MAG_W'(-i_v[i]) : MAG_W'(i_v[i]);
        end
        w_max = w_mag[0];
        if (w_mag[1] > w_max) w_max = w_mag[1];
        if (w_mag[2] > w_max) w_max = w_mag[2];
    end

    // shift that brings the largest magnitude below 2^30
    always_comb begin
        w_k = '0;
        for (int b = A_W; b < MAG_W; b++) begin
            if (r_s1_m[b]) w_k = SH_W'(b - A_W + 1);
        end
    end

    always_comb begin
        w_sq_in[0] = '{n: r_s5_n, root: 64'd0, a: r_s5_a, neg: r_s5_neg};
        for (int s = 1; s < SQ_N; s++) w_sq_in[s] = r_sq[s-1];
        for (int s = 0; s < SQ_N; s++) n_sq[s] = sq_step(w_sq_in[s], SQ_N - 1 - s);
    end

    always_comb begin
        logic [LEN_W-1:0] len;
        len = r_sq[SQ_N-1].root[LEN_W-1:0];
        n_dv0.len = len;
        n_dv0.neg = r_sq[SQ_N-1].neg;
        n_dv0.q   = '0;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = (DV_W'(r_sq[SQ_N-1].a[i]) << F) + DV_W'(len >> 1);
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        t_dv x;
        logic [DV_W-1:0] dsr;
        for (int t = 0; t < Q_W; t++) begin
            x = r_dv[t];
            for (int i = 0; i < 3; i++) begin
                dsr = DV_W'(x.len) << (F - t);
                if (x.rem[i] >= dsr) begin
                    x.rem[i]        = x.rem[i] - dsr;
                    x.q[i][F - t]   = 1'b1;
                end
            end
            n_dv[t] = x;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) w_q[i] = AX_W'(r_dv[Q_W].q[i]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a   <= w_mag;
            r_s1_m   <= w_max;
            for (int i = 0; i < 3; i++) r_s1_neg[i] <= i_v[i][MAG_W-1];
            r_s2_a   <= r_s1_a;
            r_s2_neg <= r_s1_neg;
            r_s2_k   <= w_k;
            for (int i = 0; i < 3; i++) r_s3_a[i] <= A_W'(r_s2_a[i] >> r_s2_k);
            r_s3_neg <= r_s2_neg;
            for (int i = 0; i < 3; i++) r_s4_sq[i] <= r_s3_a[i] * r_s3_a[i];
            r_s4_a   <= r_s3_a;
            r_s4_neg <= r_s3_neg;
            r_s5_n   <= 64'(r_s4_sq[0]) + 64'(r_s4_sq[1]) + 64'(r_s4_sq[2]);
            r_s5_a   <= r_s4_a;
            r_s5_neg <= r_s4_neg;
            for (int s = 0; s < SQ_N; s++) r_sq[s] <= n_sq[s];
            r_dv[0] <= n_dv0;
            for (int t = 0; t < Q_W; t++) r_dv[t+1] <= n_dv[t];
            for (int i = 0; i < 3; i++) begin
                o_axis[i] <= r_dv[Q_W].neg[i] ? -w_q[i] : w_q[i];
            end
            o_zero <= (r_dv[Q_W].len == '0);
        end
    end

endmodule

// ===== sv/look_at_view_matrix.sv =====
// Right-handed look-at view matrix, signed Q.F fixed point; top level.
// Throughput is set by the four row transfers per item on the single result
// channel; the pipeline takes a new item unless a finished item cannot be loaded.
// Reset: i_rst_n synchronous, active low; clears valid bits and the row
// serializer, datapath registers are not reset. Depends on lav_pkg, lav_norm.
module look_at_view_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_x, pos_y, pos_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [lav_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // col0, col1, col2, col3
    output logic [lav_pkg::OUT_W-1:0]     m_axis_tdata,
    // row_index[1:0], degenerate[2]
    output logic [lav_pkg::USER_W-1:0]    m_axis_tuser,
    output logic                          m_axis_tlast   // last_row
);

    localparam int F     = lav_pkg::FRAC_BITS;
    localparam int VW    = lav_pkg::VAL_W;
    localparam int AX_W  = lav_pkg::AX_W;
    localparam int CR_W  = lav_pkg::CR_W;
    localparam int L     = lav_pkg::NORM_LAT;
    localparam int P2_W  = 2 * AX_W;        // s*f product
    localparam int C2_W  = 2 * AX_W + 1;    // s x f component
    localparam int S_W   = CR_W + 2;        // sum of three axis*pos products
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // side payload that rides beside each normalizer
    typedef struct packed {
        logic [2:0][VW-1:0]   p;
        logic [2:0][VW-1:0]   u;
    } t_dl1;

    typedef struct packed {
        logic [2:0][VW-1:0]   p;
        logic [2:0][AX_W-1:0] f;
        logic                 deg;
    } t_dl2;

    logic adv;      // whole pipeline moves one stage
    logic load;     // serializer takes the finished item

    // stage 0: input register
    logic signed [VW-1:0]   r0_p [3];
    logic signed [VW-1:0]   r0_t [3];
    logic signed [VW-1:0]   r0_u [3];
    logic                   r0_v;
    // stage 1: forward difference, exact
    logic signed [VW:0]     r1_d [3];
    logic signed [VW-1:0]   r1_p [3];
    logic signed [VW-1:0]   r1_u [3];
    logic                   r1_v;
    logic signed [CR_W-1:0] w_n1_in [3];
    // first normalizer
    t_dl1                   r_dl1 [L];
    logic [L-1:0]           r_dl1_v;
    logic signed [AX_W-1:0] w_f [3];
    logic                   w_z1;
    logic signed [VW-1:0]   w_p1 [3];
    logic signed [VW-1:0]   w_u1 [3];
    // stage 2/3: f x up
    logic signed [CR_W-1:0] r2_pr [6];
    logic signed [AX_W-1:0] r2_f [3];
    logic signed [VW-1:0]   r2_p [3];
    logic                   r2_deg;
    logic                   r2_v;
    logic signed [CR_W-1:0] r3_c [3];
    logic signed [AX_W-1:0] r3_f [3];
    logic signed [VW-1:0]   r3_p [3];
    logic                   r3_deg;
    logic                   r3_v;
    // second normalizer
    t_dl2                   r_dl2 [L];
    logic [L-1:0]           r_dl2_v;
    logic signed [AX_W-1:0] w_s [3];
    logic                   w_z2;
    logic signed [AX_W-1:0] w_f2 [3];
    logic signed [VW-1:0]   w_p2 [3];
    // stage 4..6: true up axis
    logic signed [P2_W-1:0] r4_pr [6];
    logic signed [AX_W-1:0] r4_s [3];
    logic signed [AX_W-1:0] r4_f [3];
    logic signed [VW-1:0]   r4_p [3];
    logic                   r4_deg;
    logic                   r4_v;
    logic signed [C2_W-1:0] r5_c [3];
    logic signed [AX_W-1:0] r5_s [3];
    logic signed [AX_W-1:0] r5_f [3];
    logic signed [VW-1:0]   r5_p [3];
    logic                   r5_deg;
    logic                   r5_v;
    logic signed [AX_W-1:0] r6_ax [3][3];   // rows s, u, -f
    logic signed [VW-1:0]   r6_p [3];
    logic                   r6_deg;
    logic                   r6_v;
    // stage 7..9: translations
    logic signed [CR_W-1:0] r7_tp [3][3];
    logic signed [AX_W-1:0] r7_ax [3][3];
    logic                   r7_deg;
    logic                   r7_v;
    logic signed [S_W-1:0]  r8_sum [3];
    logic signed [AX_W-1:0] r8_ax [3][3];
    logic                   r8_deg;
    logic                   r8_v;
    logic signed [VW-1:0]   w_tr [3];
    logic signed [VW-1:0]   r9_tr [3];
    logic signed [AX_W-1:0] r9_ax [3][3];
    logic                   r9_deg;
    logic                   r9_v;
    // row serializer
    logic                   r_busy;
    logic [1:0]             r_row;
    logic signed [VW-1:0]   r_tr [3];
    logic signed [AX_W-1:0] r_ax [3][3];
    logic                   r_deg;
    logic signed [VW-1:0]   w_col [4];

    // The serializer loads when empty or when its row 3 transfer completes;
    // the pipeline stalls only when a finished item cannot be loaded.
    assign load          = r9_v && (!r_busy || (m_axis_tready && r_row == lav_pkg::ROW_LAST));
    assign adv           = !r9_v || load;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0; r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
            r8_v <= 1'b0; r9_v <= 1'b0;
            r_dl1_v <= '0;
            r_dl2_v <= '0;
        end else if (adv) begin
            r0_v    <= s_axis_tvalid;
            r1_v    <= r0_v;
            r_dl1_v <= {r_dl1_v[L-2:0], r1_v};
            r2_v    <= r_dl1_v[L-1];
            r3_v    <= r2_v;
            r_dl2_v <= {r_dl2_v[L-2:0], r3_v};
            r4_v    <= r_dl2_v[L-1];
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
        end
    end

    // ---- forward axis ----
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r0_p[k] <= s_axis_tdata[VW*k +: VW];
                r0_t[k] <= s_axis_tdata[VW*(3+k) +: VW];
                r0_u[k] <= s_axis_tdata[VW*(6+k) +: VW];
                r1_d[k] <= (VW+1)'(r0_t[k]) - (VW+1)'(r0_p[k]);
                r1_p[k] <= r0_p[k];
                r1_u[k] <= r0_u[k];
            end
            r_dl1[0] <= '{p: {r1_p[2], r1_p[1], r1_p[0]}, u: {r1_u[2], r1_u[1], r1_u[0]}};
            for (int s = 1; s < L; s++) r_dl1[s] <= r_dl1[s-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n1_in[k] = CR_W'(r1_d[k]);
            w_p1[k]    = $signed(r_dl1[L-1].p[k]);
            w_u1[k]    = $signed(r_dl1[L-1].u[k]);
        end
    end

    lav_norm u_norm_fwd (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_v    (w_n1_in),
        .o_axis (w_f),
        .o_zero (w_z1)
    );

    // ---- side axis: f x up, exact, then normalized ----
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pr[0] <= w_f[1] * w_u1[2];
            r2_pr[1] <= w_f[2] * w_u1[1];
            r2_pr[2] <= w_f[2] * w_u1[0];
            r2_pr[3] <= w_f[0] * w_u1[2];
            r2_pr[4] <= w_f[0] * w_u1[1];
            r2_pr[5] <= w_f[1] * w_u1[0];
            r2_f     <= w_f;
            r2_p     <= w_p1;
            r2_deg   <= w_z1;
            r3_c[0]  <= r2_pr[0] - r2_pr[1];
            r3_c[1]  <= r2_pr[2] - r2_pr[3];
            r3_c[2]  <= r2_pr[4] - r2_pr[5];
            r3_f     <= r2_f;
            r3_p     <= r2_p;
            r3_deg   <= r2_deg;
            r_dl2[0] <= '{p: {r3_p[2], r3_p[1], r3_p[0]},
                          f: {r3_f[2], r3_f[1], r3_f[0]},
                          deg: r3_deg};
            for (int s = 1; s < L; s++) r_dl2[s] <= r_dl2[s-1];
        end
    end

    lav_norm u_norm_side (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_v    (r3_c),
        .o_axis (w_s),
        .o_zero (w_z2)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_f2[k] = $signed(r_dl2[L-1].f[k]);
            w_p2[k] = $signed(r_dl2[L-1].p[k]);
        end
    end

    // ---- true up axis: s x f rounded back to Q.F ----
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_pr[0] <= w_s[1] * w_f2[2];
            r4_pr[1] <= w_s[2] * w_f2[1];
            r4_pr[2] <= w_s[2] * w_f2[0];
            r4_pr[3] <= w_s[0] * w_f2[2];
            r4_pr[4] <= w_s[0] * w_f2[1];
            r4_pr[5] <= w_s[1] * w_f2[0];
            r4_s     <= w_s;
            r4_f     <= w_f2;
            r4_p     <= w_p2;
            r4_deg   <= r_dl2[L-1].deg | w_z2;
            r5_c[0]  <= C2_W'(r4_pr[0]) - C2_W'(r4_pr[1]);
            r5_c[1]  <= C2_W'(r4_pr[2]) - C2_W'(r4_pr[3]);
            r5_c[2]  <= C2_W'(r4_pr[4]) - C2_W'(r4_pr[5]);
            r5_s     <= r4_s;
            r5_f     <= r4_f;
            r5_p     <= r4_p;
            r5_deg   <= r4_deg;
            for (int k = 0; k < 3; k++) begin
                r6_ax[0][k] <= r5_s[k];
                r6_ax[1][k] <= AX_W'(lav_pkg::lav_round(64'(r5_c[k])));
                r6_ax[2][k] <= -r5_f[k];
            end
            r6_p   <= r5_p;
            r6_deg <= r5_deg;
        end
    end

    // ---- translation column: -(axis . pos), rounded and saturated ----
    always_comb begin
        logic signed [63:0] rs;
        logic signed [63:0] t;
        for (int r = 0; r < 3; r++) begin
            rs = lav_pkg::lav_round(64'(r8_sum[r]));
            t  = -rs;
            if (t > SAT_HI)      w_tr[r] = VW'(SAT_HI);
            else if (t < SAT_LO) w_tr[r] = VW'(SAT_LO);
            else                 w_tr[r] = VW'(t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) r7_tp[r][k] <= r6_ax[r][k] * r6_p[k];
                r8_sum[r] <= S_W'(r7_tp[r][0]) + S_W'(r7_tp[r][1]) + S_W'(r7_tp[r][2]);
            end
            r7_ax  <= r6_ax;
            r7_deg <= r6_deg;
            r8_ax  <= r7_ax;
            r8_deg <= r7_deg;
            r9_tr  <= w_tr;
            r9_ax  <= r8_ax;
            r9_deg <= r8_deg;
        end
    end

    // ---- row serializer: four transfers per item ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_row  <= '0;
        end else if (r_busy && m_axis_tready) begin
            if (r_row == lav_pkg::ROW_LAST) r_busy <= 1'b0;
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tr  <= r9_tr;
            r_ax  <= r9_ax;
            r_deg <= r9_deg;
        end
    end

    // degenerate items read zero in every column, row 3 included
    always_comb begin
        for (int k = 0; k < 4; k++) w_col[k] = '0;
        if (!r_deg) begin
            if (r_row == lav_pkg::ROW_LAST) begin
                w_col[3] = VW'(1) << F;
            end else begin
                for (int k = 0; k < 3; k++) w_col[k] = VW'(r_ax[r_row][k]);
                w_col[3] = r_tr[r_row];
            end
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = {w_col[3], w_col[2], w_col[1], w_col[0]};
    assign m_axis_tuser  = {r_deg, r_row};
    assign m_axis_tlast  = (r_row == lav_pkg::ROW_LAST);

endmodule
